@@ rtl/kti_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyframe track interpolator package
// Shared sizes, command and status codes, cell and divider control types,
// and the cosine ease table.
// ----------------------------------------------------------------------------
`default_nettype none

package kti_pkg;

   localparam int MAX_FRAMES     = 64;
   localparam int CNT_W          = $clog2(MAX_FRAMES + 1);
   localparam int IDX_W          = $clog2(MAX_FRAMES);

   localparam int COS_TABLE_SIZE = 256;
   localparam int COS_BITS       = $clog2(COS_TABLE_SIZE);

   localparam int DIVIDEND_W     = 33;
   localparam int QUOT_W         = 16;
   localparam int DIV_STEP_W     = 6;
   localparam logic [DIV_STEP_W-1:0] TIME_DIV_STEPS  = DIV_STEP_W'(DIVIDEND_W);
   localparam logic [DIV_STEP_W-1:0] RATIO_DIV_STEPS = DIV_STEP_W'(QUOT_W);

   localparam logic [16:0] W_ONE = 17'd65536;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_ADD      = 3'd1,
      CMD_REMOVE   = 3'd2,
      CMD_SET_TIME = 3'd3,
      CMD_RESET    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

   localparam logic [1:0] MODE_COSINE = 2'd1;
   localparam logic [1:0] MODE_STEP   = 2'd2;

   localparam logic [2:0] REG_MIN_VALUE = 3'd0;
   localparam logic [2:0] REG_MAX_VALUE = 3'd1;
   localparam logic [2:0] REG_SPEED     = 3'd2;
   localparam logic [2:0] REG_MODE      = 3'd3;
   localparam logic [2:0] REG_PLAYING   = 3'd4;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CMP,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_REPLACE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        valid;
      logic        past_idx;
   } cell_ctl_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
   } div_req_type;

   typedef logic [16:0] cos_tab_type [0:COS_TABLE_SIZE];

   // (1 - cos(theta)) / 2 by a truncated Q30 series, rounded to Q16
   function automatic logic [16:0] ease_entry(input int unsigned i);
      logic [63:0] theta;
      logic [63:0] t2;
      logic [63:0] h;
      theta = (PI_Q30 * 64'(i)) / 64'(COS_TABLE_SIZE);
      t2    = (theta * theta) >> 30;
      h     = ONE_Q30;
      h     = ONE_Q30 - ((t2 * h) >> 30) / 64'd132;
      h     = ONE_Q30 - ((t2 * h) >> 30) / 64'd90;
      h     = ONE_Q30 - ((t2 * h) >> 30) / 64'd56;
      h     = ONE_Q30 - ((t2 * h) >> 30) / 64'd30;
      h     = ONE_Q30 - ((t2 * h) >> 30) / 64'd12;
      h     = ((t2 * h) >> 30) / 64'd4;
      return 17'((h + 64'd8192) >> 14);
   endfunction

   function automatic cos_tab_type build_cos_tab();
      cos_tab_type tab;
      for (int i = 0; i <= COS_TABLE_SIZE; i++) begin
         if (2 * i <= COS_TABLE_SIZE) begin
            tab[i] = ease_entry(i);
         end else begin
            tab[i] = W_ONE - ease_entry(COS_TABLE_SIZE - i);
         end
      end
      return tab;
   endfunction

   localparam cos_tab_type COS_TAB = build_cos_tab();

endpackage

`default_nettype wire

@@ rtl/keyframe_track_interpolator.sv @@
// ----------------------------------------------------------------------------
// Keyframe track interpolator
// Sorted keyframe table in a row of cells with a sequencer that adds,
// removes, seeks and plays back with linear, cosine or step interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat (tick, add, remove, set time, reset);
//   rsp_* returns one beat per command with the value, playback time,
//   frame count and status after it. csr_* is an APB port for the clamp
//   bounds, speed, interpolation mode and play enable; write it while idle.
// Sequencing:
//   One command is worked at a time. Add, remove, reset and set time on an
//   empty table do not use the divider. Set time with frames and a tick
//   can wait on the 33-step wrap remainder, and a tick on the 16-step
//   ratio division, in the shared bit-serial divider.
// Reset:
//   Clears the table (count zero), time and value to zero, and restores the
//   register defaults. No clearing pass is needed.
// Stall:
//   A finished result is held in the output register until rsp_ready; the
//   next command is taken meanwhile and waits for that register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_track_interpolator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_cmd,
   input  logic [15:0]         req_delta_ms,
   input  logic signed [31:0]  req_key_time,
   input  logic signed [31:0]  req_key_value,
   input  logic [5:0]          req_key_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_value,
   output logic signed [31:0]  rsp_play_time,
   output logic [6:0]          rsp_frame_count,
   output logic [1:0]          rsp_status,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import kti_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WRAP,
      ST_WRAP_DIV,
      ST_INT_CMP,
      ST_INT_SEL,
      ST_INT_PREP,
      ST_INT_DIV,
      ST_COS,
      ST_COS_MUL,
      ST_MUL,
      ST_FIN,
      ST_ADD_WR,
      ST_FIX,
      ST_RESP
   } state_type;

   // configuration
   logic signed [31:0] min_ff;
   logic signed [31:0] max_ff;
   logic signed [15:0] speed_ff;
   logic [1:0]         mode_ff;
   logic               playing_ff;

   // sequencer and track state
   state_type          state_ff;
   cmd_type            cmd_ff;
   logic [15:0]        delta_ff;
   logic signed [31:0] kt_ff;
   logic signed [31:0] kv_ff;
   logic [IDX_W-1:0]   kidx_ff;
   logic [CNT_W-1:0]   count_ff;
   logic signed [31:0] cur_time_ff;
   logic signed [31:0] cur_val_ff;
   status_type         status_ff;
   logic signed [32:0] t_ff;
   logic               wrap_below_ff;
   logic signed [31:0] pt_ff;
   logic signed [31:0] pv_ff;
   logic signed [31:0] nt_ff;
   logic signed [31:0] nv_ff;
   logic signed [32:0] diff_ff;
   logic [16:0]        w_ff;
   logic [16:0]        cbase_ff;
   logic signed [17:0] cdiff_ff;
   logic [15:0]        cfrac_ff;
   logic signed [50:0] prod_ff;

   // result register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic signed [31:0] rsp_time_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   status_type         rsp_status_ff;

   // cell row
   cell_op_type        cell_op;
   cell_ctl_type       c_ctl [MAX_FRAMES];
   logic signed [31:0] c_time [MAX_FRAMES];
   logic signed [31:0] c_value [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] c_ltv;
   logic [MAX_FRAMES-1:0] c_eqv;
   logic [MAX_FRAMES:0]   lev_ext;
   logic [MAX_FRAMES:0]   valid_ext;
   logic [MAX_FRAMES:0]   edge_ext;
   logic [MAX_FRAMES:0]   last_ext;
   logic [MAX_FRAMES-1:0] prev_sel;
   logic [MAX_FRAMES-1:0] next_sel;
   logic signed [31:0]    key_time;
   logic signed [31:0]    key_value;

   logic signed [31:0] first_time;
   logic signed [31:0] last_time;
   logic signed [31:0] sel_pt;
   logic signed [31:0] sel_pv;
   logic signed [31:0] sel_nt;
   logic signed [31:0] sel_nv;

   // divider
   div_req_type           div_req;
   logic [31:0]           div_rem_init;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [31:0]           div_divisor;
   logic                  div_done;
   logic [QUOT_W-1:0]     div_quot;
   logic [31:0]           div_rem;

   // datapath helpers
   logic signed [31:0] lo_bound;
   logic signed [31:0] hi_bound;
   logic               table_full;
   logic               bad_index;
   logic signed [32:0] tick_step;
   logic signed [32:0] start33;
   logic signed [32:0] stop33;
   logic signed [32:0] span;
   logic               wrap_above;
   logic               wrap_below;
   logic signed [33:0] wrap_x;
   logic signed [33:0] wrap_y;
   logic               wrap_go;
   logic signed [32:0] den;
   logic signed [32:0] num;
   logic               ratio_go;
   logic [COS_BITS:0]  cos_idx;
   logic signed [34:0] cprod;
   logic signed [34:0] crnd;
   logic signed [50:0] mul_prod;
   logic signed [50:0] prod_rnd;
   logic signed [31:0] fix_time;
   logic               cfg_write;

   function automatic logic signed [31:0] clamp_val(input logic signed [31:0] v,
                                                    input logic signed [31:0] lo,
                                                    input logic signed [31:0] hi);
      logic signed [31:0] r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

   assign lo_bound   = (min_ff < max_ff) ? min_ff : max_ff;
   assign hi_bound   = (min_ff < max_ff) ? max_ff : min_ff;
   assign table_full = count_ff >= CNT_W'(MAX_FRAMES);
   assign bad_index  = {1'b0, kidx_ff} >= count_ff;

   // ---------------------------------------------------------------- cells
   assign key_time  = (state_ff == ST_INT_CMP) ? cur_time_ff : kt_ff;
   assign key_value = clamp_val(kv_ff, lo_bound, hi_bound);

   assign lev_ext[MAX_FRAMES]   = 1'b0;
   assign valid_ext[MAX_FRAMES] = 1'b0;
   assign edge_ext[MAX_FRAMES]  = 1'b0;
   assign last_ext[MAX_FRAMES]  = 1'b0;

   for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
      logic signed [31:0] left_time;
      logic signed [31:0] left_value;
      logic               left_ltv;
      logic signed [31:0] right_time;
      logic signed [31:0] right_value;

      assign valid_ext[k] = CNT_W'(k) < count_ff;
      assign c_ctl[k]     = '{op: cell_op, valid: valid_ext[k],
                              past_idx: (IDX_W'(k) >= kidx_ff)};
      assign edge_ext[k]  = lev_ext[k] & ~lev_ext[k+1];
      assign last_ext[k]  = valid_ext[k] & ~valid_ext[k+1];

      if (k == 0) begin : g_head
         assign left_time   = key_time;
         assign left_value  = key_value;
         assign left_ltv    = 1'b1;
         assign prev_sel[k] = ~lev_ext[0] | (edge_ext[k] & ~last_ext[k])
                              | (edge_ext[k+1] & last_ext[k+1]);
         assign next_sel[k] = 1'b0;
      end else begin : g_body
         assign left_time   = c_time[k-1];
         assign left_value  = c_value[k-1];
         assign left_ltv    = c_ltv[k-1];
         assign prev_sel[k] = (edge_ext[k] & ~last_ext[k])
                              | (edge_ext[k+1] & last_ext[k+1]);
         assign next_sel[k] = prev_sel[k-1];
      end

      if (k == MAX_FRAMES - 1) begin : g_tail
         assign right_time  = '0;
         assign right_value = '0;
      end else begin : g_inner
         assign right_time  = c_time[k+1];
         assign right_value = c_value[k+1];
      end

      kti_cell u_cell (
         .clock       (clock),
         .ctl         (c_ctl[k]),
         .key_time    (key_time),
         .key_value   (key_value),
         .left_time   (left_time),
         .left_value  (left_value),
         .left_ltv    (left_ltv),
         .right_time  (right_time),
         .right_value (right_value),
         .time_out    (c_time[k]),
         .value_out   (c_value[k]),
         .ltv         (c_ltv[k]),
         .lev         (lev_ext[k]),
         .eqv         (c_eqv[k])
      );
   end

   assign first_time = c_time[0];

   always_comb begin
      last_time = '0;
      sel_pt    = '0;
      sel_pv    = '0;
      sel_nt    = '0;
      sel_nv    = '0;
      for (int k = 0; k < MAX_FRAMES; k++) begin
         last_time = last_time | (c_time[k] & {32{last_ext[k]}});
         sel_pt    = sel_pt | (c_time[k] & {32{prev_sel[k]}});
         sel_pv    = sel_pv | (c_value[k] & {32{prev_sel[k]}});
         sel_nt    = sel_nt | (c_time[k] & {32{next_sel[k]}});
         sel_nv    = sel_nv | (c_value[k] & {32{next_sel[k]}});
      end
   end

   always_comb begin
      cell_op = CELL_HOLD;
      priority if (state_ff == ST_EXEC && cmd_ff == CMD_ADD && !table_full) begin
         cell_op = CELL_CMP;
      end else if (state_ff == ST_EXEC && cmd_ff == CMD_REMOVE && !bad_index) begin
         cell_op = CELL_REMOVE;
      end else if (state_ff == ST_INT_CMP) begin
         cell_op = CELL_CMP;
      end else if (state_ff == ST_ADD_WR) begin
         cell_op = (|c_eqv) ? CELL_REPLACE : CELL_INSERT;
      end else begin
         cell_op = CELL_HOLD;
      end
   end

   // ---------------------------------------------------------------- datapath
   assign tick_step  = 33'($signed({1'b0, delta_ff})) * 33'(speed_ff);
   assign start33    = 33'(first_time);
   assign stop33     = 33'(last_time);
   assign span       = stop33 - start33;
   assign wrap_above = t_ff > stop33;
   assign wrap_below = t_ff < start33;
   assign wrap_x     = 34'(t_ff) - 34'(stop33);
   assign wrap_y     = 34'(start33) - 34'(t_ff);
   assign wrap_go    = (state_ff == ST_WRAP) && (span > 33'sd0)
                       && (wrap_above || wrap_below);

   assign den      = 33'(nt_ff) - 33'(pt_ff);
   assign num      = 33'(cur_time_ff) - 33'(pt_ff);
   assign ratio_go = (state_ff == ST_INT_PREP) && (den > 33'sd0) && (mode_ff != MODE_STEP)
                     && (num > 33'sd0) && (num < den);

   assign cos_idx  = w_ff[16 -: (COS_BITS + 1)];
   assign cprod    = 35'(cdiff_ff) * 35'($signed({1'b0, cfrac_ff}));
   assign crnd     = (cprod + 35'sd32768) >>> 16;
   assign mul_prod = 51'(diff_ff) * 51'($signed({1'b0, w_ff}));
   assign prod_rnd = (prod_ff + 51'sd32768) >>> 16;

   always_comb begin
      fix_time = cur_time_ff;
      if (fix_time < first_time) begin
         fix_time = first_time;
      end
      if (fix_time > last_time) begin
         fix_time = last_time;
      end
   end

   always_comb begin
      div_req.start = wrap_go | ratio_go;
      div_req.steps = wrap_go ? TIME_DIV_STEPS : RATIO_DIV_STEPS;
      div_rem_init  = wrap_go ? 32'd0 : num[31:0];
      div_dividend  = wrap_go ? (wrap_above ? wrap_x[DIVIDEND_W-1:0]
                                            : wrap_y[DIVIDEND_W-1:0])
                              : '0;
      div_divisor   = wrap_go ? span[31:0] : den[31:0];
   end

   kti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req),
      .rem_init  (div_rem_init),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // ---------------------------------------------------------------- sequencer
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_time_ff  <= '0;
         cur_val_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff    <= cmd_type'(req_cmd);
                  delta_ff  <= req_delta_ms;
                  kt_ff     <= req_key_time;
                  kv_ff     <= req_key_value;
                  kidx_ff   <= req_key_index;
                  status_ff <= STATUS_OK;
                  state_ff  <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_RESP;
               case (cmd_ff)
                  CMD_TICK: begin
                     if (playing_ff && count_ff == CNT_W'(1)) begin
                        cur_time_ff <= first_time;
                        cur_val_ff  <= c_value[0];
                     end else if (playing_ff && count_ff != '0) begin
                        t_ff     <= 33'(cur_time_ff) + tick_step;
                        state_ff <= ST_WRAP;
                     end
                  end
                  CMD_ADD: begin
                     if (table_full) begin
                        status_ff <= STATUS_FULL;
                     end else begin
                        state_ff <= ST_ADD_WR;
                     end
                  end
                  CMD_REMOVE: begin
                     if (bad_index) begin
                        status_ff <= STATUS_BAD_INDEX;
                     end else begin
                        count_ff <= count_ff - 1'b1;
                        state_ff <= ST_FIX;
                     end
                  end
                  CMD_SET_TIME: begin
                     if (count_ff == '0) begin
                        cur_time_ff <= kt_ff;
                     end else begin
                        t_ff     <= 33'(kt_ff);
                        state_ff <= ST_WRAP;
                     end
                  end
                  CMD_RESET: begin
                     cur_val_ff  <= clamp_val(min_ff, lo_bound, hi_bound);
                     cur_time_ff <= (count_ff != '0) ? first_time : 32'sd0;
                  end
                  default: begin
                  end
               endcase
            end
            ST_WRAP: begin
               wrap_below_ff <= !wrap_above;
               if (wrap_go) begin
                  state_ff <= ST_WRAP_DIV;
               end else begin
                  cur_time_ff <= (span > 33'sd0) ? t_ff[31:0] : first_time;
                  state_ff    <= (cmd_ff == CMD_TICK) ? ST_INT_CMP : ST_RESP;
               end
            end
            ST_WRAP_DIV: begin
               if (div_done) begin
                  if (wrap_below_ff) begin
                     cur_time_ff <= (div_rem == '0) ? first_time : last_time - div_rem;
                  end else begin
                     cur_time_ff <= (div_rem == '0) ? last_time : first_time + div_rem;
                  end
                  state_ff <= (cmd_ff == CMD_TICK) ? ST_INT_CMP : ST_RESP;
               end
            end
            ST_INT_CMP: begin
               state_ff <= ST_INT_SEL;
            end
            ST_INT_SEL: begin
               pt_ff    <= sel_pt;
               pv_ff    <= sel_pv;
               nt_ff    <= sel_nt;
               nv_ff    <= sel_nv;
               state_ff <= ST_INT_PREP;
            end
            ST_INT_PREP: begin
               diff_ff <= 33'(nv_ff) - 33'(pv_ff);
               priority if (den <= 33'sd0 || mode_ff == MODE_STEP) begin
                  cur_val_ff <= pv_ff;
                  state_ff   <= ST_RESP;
               end else if (num <= 33'sd0) begin
                  w_ff     <= '0;
                  state_ff <= (mode_ff == MODE_COSINE) ? ST_COS : ST_MUL;
               end else if (num >= den) begin
                  w_ff     <= W_ONE;
                  state_ff <= (mode_ff == MODE_COSINE) ? ST_COS : ST_MUL;
               end else begin
                  state_ff <= ST_INT_DIV;
               end
            end
            ST_INT_DIV: begin
               if (div_done) begin
                  w_ff     <= {1'b0, div_quot};
                  state_ff <= (mode_ff == MODE_COSINE) ? ST_COS : ST_MUL;
               end
            end
            ST_COS: begin
               if (cos_idx >= (COS_BITS + 1)'(COS_TABLE_SIZE)) begin
                  w_ff     <= W_ONE;
                  state_ff <= ST_MUL;
               end else begin
                  cbase_ff <= COS_TAB[cos_idx];
                  cdiff_ff <= $signed({1'b0, COS_TAB[cos_idx + 1'b1]})
                              - $signed({1'b0, COS_TAB[cos_idx]});
                  cfrac_ff <= {w_ff[15-COS_BITS:0], COS_BITS'(0)};
                  state_ff <= ST_COS_MUL;
               end
            end
            ST_COS_MUL: begin
               w_ff     <= cbase_ff + crnd[16:0];
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= mul_prod;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               cur_val_ff <= pv_ff + prod_rnd[31:0];
               state_ff   <= ST_RESP;
            end
            ST_ADD_WR: begin
               if (!(|c_eqv)) begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= ST_FIX;
            end
            ST_FIX: begin
               // table has settled: pull time back into the new span, or zero it when the table is empty
               if (count_ff == '0) begin
                  cur_time_ff <= '0;
                  cur_val_ff  <= clamp_val(cur_val_ff, lo_bound, hi_bound);
               end else if (cmd_ff == CMD_ADD && count_ff == CNT_W'(1)) begin
                  cur_time_ff <= kt_ff;
                  cur_val_ff  <= key_value;
               end else begin
                  cur_time_ff <= fix_time;
               end
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= cur_val_ff;
                  rsp_time_ff   <= cur_time_ff;
                  rsp_count_ff  <= count_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_play_time   = rsp_time_ff;
   assign rsp_frame_count = 7'(rsp_count_ff);
   assign rsp_status      = rsp_status_ff;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= 32'sd0;
         max_ff     <= 32'sd65536;
         speed_ff   <= 16'sd256;
         mode_ff    <= 2'd0;
         playing_ff <= 1'b1;
      end else if (cfg_write) begin
         case (csr_paddr[4:2])
            REG_MIN_VALUE: min_ff     <= csr_pwdata;
            REG_MAX_VALUE: max_ff     <= csr_pwdata;
            REG_SPEED:     speed_ff   <= csr_pwdata[15:0];
            REG_MODE:      mode_ff    <= csr_pwdata[1:0];
            REG_PLAYING:   playing_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_MIN_VALUE: csr_prdata = min_ff;
         REG_MAX_VALUE: csr_prdata = max_ff;
         REG_SPEED:     csr_prdata = 32'(speed_ff);
         REG_MODE:      csr_prdata = {30'd0, mode_ff};
         REG_PLAYING:   csr_prdata = {31'd0, playing_ff};
         default:       csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/kti_cell.sv @@
// ----------------------------------------------------------------------------
// Keyframe cell
// Holds one frame of the sorted table; compares against a broadcast key and
// shifts with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_cell (
   input  logic                  clock,
   input  kti_pkg::cell_ctl_type ctl,
   input  logic signed [31:0]    key_time,
   input  logic signed [31:0]    key_value,
   input  logic signed [31:0]    left_time,
   input  logic signed [31:0]    left_value,
   input  logic                  left_ltv,
   input  logic signed [31:0]    right_time,
   input  logic signed [31:0]    right_value,
   output logic signed [31:0]    time_out,
   output logic signed [31:0]    value_out,
   output logic                  ltv,
   output logic                  lev,
   output logic                  eqv
);
   import kti_pkg::*;

   logic signed [31:0] time_ff;
   logic signed [31:0] value_ff;
   logic               lt_ff;
   logic               eq_ff;

   assign time_out  = time_ff;
   assign value_out = value_ff;
   assign ltv       = ctl.valid & lt_ff;
   assign eqv       = ctl.valid & eq_ff;
   assign lev       = ctl.valid & (lt_ff | eq_ff);

   always_ff @(posedge clock) begin
      unique case (ctl.op)
         CELL_HOLD: begin
         end
         CELL_CMP: begin
            lt_ff <= time_ff < key_time;
            eq_ff <= time_ff == key_time;
         end
         CELL_INSERT: begin
            // frames before the key stay, the first later one takes the key
            if (!ltv) begin
               if (left_ltv) begin
                  time_ff  <= key_time;
                  value_ff <= key_value;
               end else begin
                  time_ff  <= left_time;
                  value_ff <= left_value;
               end
            end
         end
         CELL_REMOVE: begin
            if (ctl.past_idx) begin
               time_ff  <= right_time;
               value_ff <= right_value;
            end
         end
         CELL_REPLACE: begin
            if (eqv) begin
               value_ff <= key_value;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/kti_div.sv @@
// ----------------------------------------------------------------------------
// Keyframe divider
// Restoring divider, one quotient bit per cycle; serves both the time wrap
// remainder and the interpolation ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_div (
   input  logic                            clock,
   input  logic                            reset,
   input  kti_pkg::div_req_type            req,
   input  logic [31:0]                     rem_init,
   input  logic [kti_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [31:0]                     divisor,
   output logic                            done,
   output logic [kti_pkg::QUOT_W-1:0]      quotient,
   output logic [31:0]                     remainder
);
   import kti_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_STEP_W-1:0] cnt_ff;
   logic [31:0]           rem_ff;
   logic [DIVIDEND_W-1:0] dvd_ff;
   logic [31:0]           dvs_ff;
   logic [QUOT_W-1:0]     quot_ff;

   logic [32:0]           rem_sh;
   logic                  fits;

   assign rem_sh    = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign fits      = rem_sh >= {1'b0, dvs_ff};
   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= rem_init;
         dvd_ff  <= dividend;
         dvs_ff  <= divisor;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
         dvd_ff  <= {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QUOT_W-2:0], fits};
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyframe track interpolator testbench
// Drives command beats with random gaps and checks every result beat, field
// by field and in order, against a predictor of the track that runs as each
// command is issued, or against fixed values for typed rows. Phases change
// the clamp, speed, mode and play registers over the APB port while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import kti_pkg::*;

   localparam logic [2:0] CMD_SPARE_5 = 3'd5;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam logic [1:0] MODE_LINEAR     = 2'd0;
   localparam logic [1:0] MODE_LINEAR_ALT = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 80;
   localparam int N_DIRECTED = 22;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] ptime;
      logic [6:0]  frames;
      logic [1:0]  status;
   } track_result_t;

   typedef struct packed {
      logic [2:0]    cmd;
      logic [15:0]   delta;
      logic [31:0]   kt;
      logic [31:0]   kv;
      logic [5:0]    kidx;
      bit            typed;
      track_result_t res;
   } cmd_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_cmd = '0;
   logic [15:0] req_delta_ms = '0;
   logic signed [31:0] req_key_time = '0;
   logic signed [31:0] req_key_value = '0;
   logic [5:0] req_key_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_value;
   logic signed [31:0] rsp_play_time;
   logic [6:0] rsp_frame_count;
   logic [1:0] rsp_status;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   keyframe_track_interpolator DUT (.*);

   always #4 clock = ~clock;

   // predictor state
   longint frame_t [0:MAX_FRAMES-1];
   longint frame_v [0:MAX_FRAMES-1];
   int     n_frames;
   longint play_t, play_v;
   longint lo_reg, hi_reg, speed;
   logic [1:0] mode;
   bit     playing;
   longint ease_tab [0:COS_TABLE_SIZE];

   track_result_t pending_results [$];
   int  mismatches = 0;
   int  cycles = 0;
   bit  long_hold = 0;
   bit  burst = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** keyframe_track_interpolator: FAILED **");
         $finish;
      end
   end

   function automatic longint series_entry(int i);
      bit [63:0] theta, t2, h;
      theta = (64'd3373259426 * 64'(i)) / 64'(COS_TABLE_SIZE);
      t2 = (theta * theta) >> 30;
      h = 64'd1073741824;
      h = 64'd1073741824 - ((t2 * h) >> 30) / 64'd132;
      h = 64'd1073741824 - ((t2 * h) >> 30) / 64'd90;
      h = 64'd1073741824 - ((t2 * h) >> 30) / 64'd56;
      h = 64'd1073741824 - ((t2 * h) >> 30) / 64'd30;
      h = 64'd1073741824 - ((t2 * h) >> 30) / 64'd12;
      h = ((t2 * h) >> 30) / 64'd4;
      return longint'((h + 64'd8192) >> 14);
   endfunction

   function automatic longint round16(longint x);
      return (x + 32768) >>> 16;
   endfunction

   function automatic longint clamp_to_range(longint x);
      longint lo, hi;
      lo = (lo_reg < hi_reg) ? lo_reg : hi_reg;
      hi = (lo_reg < hi_reg) ? hi_reg : lo_reg;
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic longint wrap_into_span(longint t);
      longint first, last, d;
      first = frame_t[0];
      last = frame_t[n_frames-1];
      d = last - first;
      if (d <= 0) return first;
      if (t > last) t -= ((t - last + d - 1) / d) * d;
      if (t < first) t += ((first - t + d - 1) / d) * d;
      return t;
   endfunction

   function automatic void pin_time_to_span();
      if (play_t < frame_t[0]) play_t = frame_t[0];
      if (play_t > frame_t[n_frames-1]) play_t = frame_t[n_frames-1];
   endfunction

   function automatic void sample_track();
      int i, lo_i, hi_i;
      longint num, den, r, w, pos, idx, frac;
      i = 0;
      if (n_frames == 1) begin
         play_v = frame_v[0];
         return;
      end
      while (i < n_frames && frame_t[i] <= play_t) i++;
      if (i == n_frames) begin
         hi_i = n_frames - 1; lo_i = n_frames - 2;
      end else if (i == 0) begin
         lo_i = 0; hi_i = 1;
      end else begin
         lo_i = i - 1; hi_i = i;
      end
      den = frame_t[hi_i] - frame_t[lo_i];
      num = play_t - frame_t[lo_i];
      if (den <= 0 || mode == MODE_STEP) begin
         play_v = frame_v[lo_i];
         return;
      end
      if (num <= 0) r = 0;
      else if (num >= den) r = 65536;
      else r = (num << 16) / den;
      w = r;
      if (mode == MODE_COSINE) begin
         pos = r * COS_TABLE_SIZE;
         idx = pos >> 16;
         frac = pos & 65535;
         if (idx >= COS_TABLE_SIZE) w = 65536;
         else w = ease_tab[idx] + round16((ease_tab[idx+1] - ease_tab[idx]) * frac);
      end
      play_v = frame_v[lo_i] + round16((frame_v[hi_i] - frame_v[lo_i]) * w);
   endfunction

   // advance the predicted track by one command and return its result
   function automatic track_result_t track_step(logic [2:0] cmd, logic [15:0] delta,
                                               logic [31:0] kt_bits, logic [31:0] kv_bits,
                                               logic [5:0] kidx);
      track_result_t res;
      longint kt, kv;
      int i, j;
      logic [1:0] st;
      kt = longint'($signed(kt_bits));
      kv = longint'($signed(kv_bits));
      st = STATUS_OK;
      i = 0;
      case (cmd)
         CMD_TICK: begin
            if (playing && n_frames > 0) begin
               if (n_frames > 1)
                  play_t = wrap_into_span(play_t + longint'(delta) * speed);
               else
                  play_t = frame_t[0];
               sample_track();
            end
         end
         CMD_ADD: begin
            if (n_frames >= MAX_FRAMES) begin
               st = STATUS_FULL;
            end else begin
               kv = clamp_to_range(kv);
               while (i < n_frames && frame_t[i] < kt) i++;
               if (i < n_frames && frame_t[i] == kt) begin
                  frame_v[i] = kv;
               end else begin
                  for (j = n_frames; j > i; j--) begin
                     frame_t[j] = frame_t[j-1];
                     frame_v[j] = frame_v[j-1];
                  end
                  frame_t[i] = kt;
                  frame_v[i] = kv;
                  n_frames++;
               end
               pin_time_to_span();
               if (n_frames == 1) begin
                  play_t = kt;
                  play_v = kv;
               end
            end
         end
         CMD_REMOVE: begin
            if (kidx >= n_frames) begin
               st = STATUS_BAD_INDEX;
            end else begin
               for (j = kidx; j + 1 < n_frames; j++) begin
                  frame_t[j] = frame_t[j+1];
                  frame_v[j] = frame_v[j+1];
               end
               n_frames--;
               if (n_frames > 0) begin
                  pin_time_to_span();
               end else begin
                  play_t = 0;
                  play_v = clamp_to_range(play_v);
               end
            end
         end
         CMD_SET_TIME: play_t = (n_frames > 0) ? wrap_into_span(kt) : kt;
         CMD_RESET: begin
            play_v = clamp_to_range(lo_reg);
            play_t = (n_frames > 0) ? frame_t[0] : 0;
         end
         default: ;
      endcase
      res.value = play_v[31:0];
      res.ptime = play_t[31:0];
      res.frames = 7'(n_frames);
      res.status = st;
      return res;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = {idx, 2'b00}; csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      case (idx)
         REG_MIN_VALUE: lo_reg = longint'($signed(data));
         REG_MAX_VALUE: hi_reg = longint'($signed(data));
         REG_SPEED:     speed = longint'($signed(data[15:0]));
         REG_MODE:      mode = data[1:0];
         REG_PLAYING:   playing = data[0];
         default: ;
      endcase
   endtask

   task automatic issue(cmd_row_t row);
      track_result_t res;
      int gap;
      res = track_step(row.cmd, row.delta, row.kt, row.kv, row.kidx);
      pending_results.push_back(row.typed ? row.res : res);
      gap = burst ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_cmd = row.cmd; req_delta_ms = row.delta;
      req_key_time = row.kt; req_key_value = row.kv; req_key_index = row.kidx;
      do @(posedge clock); while (!req_ready);
   endtask

   // pause the sender until every result is back, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic cmd_row_t random_row(int add_pct, int rem_pct, bit narrow);
      cmd_row_t row;
      int r;
      r = $urandom_range(0, 99);
      row.typed = 0;
      row.res = '0;
      if (r < add_pct) row.cmd = CMD_ADD;
      else if (r < add_pct + rem_pct) row.cmd = CMD_REMOVE;
      else if (r < add_pct + rem_pct + 10) row.cmd = CMD_SET_TIME;
      else if (r < add_pct + rem_pct + 14) row.cmd = CMD_RESET;
      else if (r < add_pct + rem_pct + 17) row.cmd = 3'($urandom_range(5, 7));
      else row.cmd = CMD_TICK;
      row.delta = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
      if (n_frames > 0 && $urandom_range(0, 9) == 0)
         row.kt = frame_t[$urandom_range(0, n_frames - 1)][31:0];
      else if (narrow)
         row.kt = 32'($urandom_range(0, 8191)) - 32'd4096;
      else
         row.kt = $urandom;
      row.kv = $urandom;
      if (n_frames > 0 && $urandom_range(0, 3) != 0)
         row.kidx = 6'($urandom_range(0, n_frames - 1));
      else
         row.kidx = 6'($urandom);
      return row;
   endfunction

   // result side: random stalls, none in burst phases, which also cancel a requested long hold-off
   initial begin
      int w;
      track_result_t got, want;
      forever begin
         w = long_hold ? 400 : $urandom_range(0, 15);
         if (long_hold) long_hold = 0;
         if (burst) w = 0;
         repeat (w) begin
            @(negedge clock);
            rsp_ready = 1'b0;
         end
         @(negedge clock);
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = {rsp_value, rsp_play_time, rsp_frame_count, rsp_status};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: value %h/%h time %h/%h count %0d/%0d status %0d/%0d",
                           got.value, want.value, got.ptime, want.ptime,
                           got.frames, want.frames, got.status, want.status);
            end
         end
      end
   end

   initial begin
      cmd_row_t directed [0:N_DIRECTED-1];
      int n_items;
      for (int i = 0; i <= COS_TABLE_SIZE; i++)
         if (2 * i <= COS_TABLE_SIZE) ease_tab[i] = series_entry(i);
      for (int i = 0; i <= COS_TABLE_SIZE; i++)
         if (2 * i > COS_TABLE_SIZE) ease_tab[i] = 65536 - ease_tab[COS_TABLE_SIZE - i];
      for (int i = 0; i < MAX_FRAMES; i++) begin
         frame_t[i] = 0; frame_v[i] = 0;
      end
      n_frames = 0; play_t = 0; lo_reg = 0; hi_reg = 65536; speed = 256;
      mode = MODE_LINEAR; playing = 1; play_v = 0;

      // cmd, delta, time, value, index, typed, {value, time, count, status}
      directed[0]  = '{CMD_TICK, 16'd5, 0, 0, 0, 1, '{0, 0, 0, STATUS_OK}};
      directed[1]  = '{CMD_REMOVE, 0, 0, 0, 0, 1, '{0, 0, 0, STATUS_BAD_INDEX}};
      directed[2]  = '{CMD_SET_TIME, 0, 1000, 0, 0, 1, '{0, 1000, 0, STATUS_OK}};
      directed[3]  = '{CMD_RESET, 0, 0, 0, 0, 1, '{0, 0, 0, STATUS_OK}};
      directed[4]  = '{CMD_ADD, 0, 256, 32'h7fffffff, 0, 1, '{65536, 256, 1, STATUS_OK}};
      directed[5]  = '{CMD_TICK, 16'd100, 0, 0, 0, 1, '{65536, 256, 1, STATUS_OK}};
      directed[6]  = '{CMD_ADD, 0, 32'h80000000, 32'h80000000, 0, 0, '0};
      directed[7]  = '{CMD_ADD, 0, 32'h7fffffff, 32'd32768, 0, 0, '0};
      directed[8]  = '{CMD_ADD, 0, 256, 32'd100, 0, 0, '0};
      directed[9]  = '{CMD_TICK, 16'hffff, 0, 0, 0, 0, '0};
      directed[10] = '{CMD_TICK, 0, 0, 0, 0, 0, '0};
      directed[11] = '{CMD_SET_TIME, 0, 32'h80000000, 0, 0, 0, '0};
      directed[12] = '{CMD_SET_TIME, 0, -32'sd1000, 0, 0, 0, '0};
      directed[13] = '{CMD_REMOVE, 0, 0, 0, 6'd63, 0, '0};
      directed[14] = '{CMD_SPARE_5, 0, 0, 0, 0, 0, '0};
      directed[15] = '{CMD_SPARE_7, 16'hffff, 32'hffffffff, 32'hffffffff, 6'd63, 0, '0};
      directed[16] = '{CMD_RESET, 0, 0, 0, 0, 0, '0};
      directed[17] = '{CMD_REMOVE, 0, 0, 0, 6'd2, 0, '0};
      directed[18] = '{CMD_REMOVE, 0, 0, 0, 6'd0, 0, '0};
      directed[19] = '{CMD_REMOVE, 0, 0, 0, 6'd0, 0, '0};
      directed[20] = '{CMD_ADD, 0, 32'h7fffffff, 32'd40000, 0, 0, '0};
      directed[21] = '{CMD_ADD, 0, -32'sd600, 32'd1, 0, 0, '0};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) issue(directed[i]);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            1: begin
               csr_write(REG_MIN_VALUE, 32'h80000000);
               csr_write(REG_MAX_VALUE, 32'h7fffffff);
               csr_write(REG_SPEED, 32'h7fff);
               csr_write(REG_MODE, MODE_COSINE);
            end
            2: begin
               csr_write(REG_SPEED, 32'h8000);
               csr_write(REG_MODE, MODE_STEP);
            end
            3: begin
               csr_write(REG_MIN_VALUE, 32'd100000);
               csr_write(REG_MAX_VALUE, -32'sd100000);
               csr_write(REG_MODE, MODE_LINEAR_ALT);
               csr_write(REG_SPEED, 32'd256);
            end
            5: csr_write(REG_PLAYING, 32'd0);
            6: begin
               csr_write(REG_PLAYING, 32'd1);
               csr_write(REG_SPEED, 32'd0);
               csr_write(REG_MODE, MODE_COSINE);
            end
            8, 9: begin
               csr_write(REG_MIN_VALUE, $urandom);
               csr_write(REG_MAX_VALUE, $urandom);
               csr_write(REG_SPEED, $urandom);
               csr_write(REG_MODE, 32'($urandom_range(0, 3)));
               csr_write(REG_PLAYING, 32'($urandom_range(0, 1)));
            end
            default: ;
         endcase
         burst = (ph == 3) || (ph == 6);
         if (ph == 3) long_hold = 1;
         n_items = (ph == 4) ? 100 : 45;
         for (int k = 0; k < n_items; k++) begin
            case (ph)
               4: issue(random_row(90, 0, ph[0]));
               7: issue(random_row(5, 60, 0));
               default: issue(random_row(30, 10, ph[0]));
            endcase
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("** keyframe_track_interpolator: PASSED **");
      end else begin
         $display("** keyframe_track_interpolator: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
